### rtl/core/circle_pair_overlap_resolver_assert.svh
// Assertion macros used by the checker of the circle pair overlap resolver.
// Each macro expands to one labeled concurrent assertion clocked on clk and
// disabled while arst_n is low; the including module must have both signals.
`ifndef CIRCLE_PAIR_OVERLAP_RESOLVER_ASSERT_SVH
`define CIRCLE_PAIR_OVERLAP_RESOLVER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define CPOR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define CPOR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/cpor_pkg.sv
// Package for the circle pair overlap resolver: widths, pipeline depths,
// result flag positions and the sideband record carried along the pipeline.
// No dependencies.
package cpor_pkg;

	localparam int POS_W       = 32;
	localparam int RAD_W       = 31;
	localparam int SQ_STAGES   = 32;
	localparam int DIV_STAGES  = 32;
	// front four stages, sqrt, pen, products, divide, products, divide, output
	localparam int PIPE_LAT    = 4 + SQ_STAGES + 2 + DIV_STAGES + 1 + DIV_STAGES + 1;
	localparam int IN_TDATA_W  = 256;
	localparam int OUT_TDATA_W = 128;
	localparam int OUT_TUSER_W = 2;

	// result flag positions in tuser
	localparam int TU_OVERLAPPED = 0;
	localparam int TU_DEGENERATE = 1;

	localparam logic signed [POS_W+1:0] SAT_MAX = 34'sd2147483647;
	localparam logic signed [POS_W+1:0] SAT_MIN = -34'sd2147483648;

	typedef struct packed {
		logic signed [POS_W-1:0] x1;
		logic signed [POS_W-1:0] y1;
		logic signed [POS_W-1:0] x2;
		logic signed [POS_W-1:0] y2;
		logic                    neg_x;
		logic                    neg_y;
		logic [POS_W-1:0]        adx;
		logic [POS_W-1:0]        ady;
		logic [POS_W-1:0]        m;
		logic [RAD_W-1:0]        im1;
		logic [RAD_W-1:0]        im2;
		logic [POS_W-1:0]        msum;
		logic [POS_W-1:0]        len;
		logic                    hit;
		logic                    degen;
	} side_t;

endpackage

### rtl/core/cpor_sqrt.sv
// Pipelined integer square root, one result bit per stage, 64-bit radicand.
// Depends on cpor_pkg for the stage count.
module cpor_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] rad,
	output logic [31:0] root
);
	import cpor_pkg::*;

	logic [33:0] rem_s  [SQ_STAGES];
	logic [31:0] root_s [SQ_STAGES];
	logic [63:0] rad_s  [SQ_STAGES];

	genvar k;
	generate
		for (k = 0; k < SQ_STAGES; k++) begin : g_stage
			logic [33:0] src_rem;
			logic [31:0] src_root;
			logic [63:0] src_rad;
			logic [35:0] cur;
			logic [35:0] trial;
			logic        ge;

			// take the previous stage, or the radicand at the head
			if (k == 0) begin : g_head
				assign src_rem  = '0;
				assign src_root = '0;
				assign src_rad  = rad;
			end else begin : g_body
				assign src_rem  = rem_s[k-1];
				assign src_root = root_s[k-1];
				assign src_rad  = rad_s[k-1];
			end

			// bring down two radicand bits and try 4*root+1
			assign cur   = {src_rem, src_rad[63:62]};
			assign trial = {2'b00, src_root, 2'b01};
			assign ge    = (cur >= trial);

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k]  <= ge ? 34'(cur - trial) : cur[33:0];
					root_s[k] <= {src_root[30:0], ge};
					rad_s[k]  <= {src_rad[61:0], 2'b00};
				end
			end
		end
	endgenerate

	assign root = root_s[SQ_STAGES-1];

endmodule

### rtl/core/cpor_div.sv
// Pipelined restoring divider, 64-bit dividend by 32-bit divisor, one
// quotient bit per stage; the quotient must fit 32 bits. Depends on cpor_pkg.
module cpor_div (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] num,
	input  logic [31:0] den,
	output logic [31:0] quo
);
	import cpor_pkg::*;

	logic [31:0] rem_s [DIV_STAGES];
	logic [31:0] lo_s  [DIV_STAGES];
	logic [31:0] den_s [DIV_STAGES];

	genvar k;
	generate
		for (k = 0; k < DIV_STAGES; k++) begin : g_stage
			logic [31:0] src_rem;
			logic [31:0] src_lo;
			logic [31:0] src_den;
			logic [32:0] cur;
			logic        ge;

			if (k == 0) begin : g_head
				assign src_rem = num[63:32];
				assign src_lo  = num[31:0];
				assign src_den = den;
			end else begin : g_body
				assign src_rem = rem_s[k-1];
				assign src_lo  = lo_s[k-1];
				assign src_den = den_s[k-1];
			end

			// shift in the next dividend bit, subtract when it fits
			assign cur = {src_rem, src_lo[31]};
			assign ge  = (cur >= {1'b0, src_den});

			// quotient bits collect in the low word as dividend bits leave
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? 32'(cur - {1'b0, src_den}) : cur[31:0];
					lo_s[k]  <= {src_lo[30:0], ge};
					den_s[k] <= src_den;
				end
			end
		end
	endgenerate

	assign quo = lo_s[DIV_STAGES-1];

endmodule

### rtl/core/circle_pair_overlap_resolver.sv
// Top level of the circle pair overlap resolver.
// Depends on cpor_pkg, cpor_sqrt and cpor_div.
//
// Usage: one candidate pair of circles enters per transfer on the s_ channel;
// one corrected pair leaves per transfer on the m_ channel, in order.
// Overlapping circles are pushed apart along the center line, the overlap
// shared in proportion to inverse mass; positions saturate to 32 bits.
// Overlapping circles with coincident centers or zero total inverse mass
// give unchanged positions and the degenerate flag.
// The path from input transfer to result valid runs through the 32-stage
// square root and two 32-stage dividers in series.
// Throughput: one pair per cycle while the receiver does not stall.
// Reset clears all valid bits; the pipeline is empty afterward and
// s_tready is high. When the receiver stalls with a result waiting, the
// whole pipeline holds and s_tready drops in the same cycle; nothing is
// lost or repeated.
module circle_pair_overlap_resolver (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// first_x, first_y, first_radius, first_inv_mass,
	// second_x, second_y, second_radius, second_inv_mass, zero pad
	input  logic [cpor_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// new_first_x, new_first_y, new_second_x, new_second_y
	output logic [cpor_pkg::OUT_TDATA_W-1:0]  m_tdata,
	// overlapped, degenerate
	output logic [cpor_pkg::OUT_TUSER_W-1:0]  m_tuser
);
	import cpor_pkg::*;

	function automatic logic [POS_W-1:0] sat32(input logic signed [POS_W+1:0] v);
		logic [POS_W-1:0] r;
		if (v > SAT_MAX)
			r = SAT_MAX[POS_W-1:0];
		else if (v < SAT_MIN)
			r = SAT_MIN[POS_W-1:0];
		else
			r = v[POS_W-1:0];
		return r;
	endfunction

	logic                en;
	logic [PIPE_LAT-1:0] vld_q;

	// advance everything unless the output holds an untaken result
	assign en       = ~vld_q[PIPE_LAT-1] | m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], s_tvalid};
		end
	end

	// stage 1: differences and sums
	logic signed [POS_W-1:0] in_x1, in_y1, in_x2, in_y2;
	logic signed [POS_W-1:0] x1_s1, y1_s1, x2_s1, y2_s1;
	logic signed [POS_W:0]   dx_s1, dy_s1;
	logic [POS_W-1:0]        m_s1, msum_s1;
	logic [RAD_W-1:0]        im1_s1, im2_s1;

	assign in_x1 = signed'(s_tdata[31:0]);
	assign in_y1 = signed'(s_tdata[63:32]);
	assign in_x2 = signed'(s_tdata[157:126]);
	assign in_y2 = signed'(s_tdata[189:158]);

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1   <= in_x1;
			y1_s1   <= in_y1;
			x2_s1   <= in_x2;
			y2_s1   <= in_y2;
			dx_s1   <= {in_x1[POS_W-1], in_x1} - {in_x2[POS_W-1], in_x2};
			dy_s1   <= {in_y1[POS_W-1], in_y1} - {in_y2[POS_W-1], in_y2};
			m_s1    <= {1'b0, s_tdata[94:64]} + {1'b0, s_tdata[220:190]};
			msum_s1 <= {1'b0, s_tdata[125:95]} + {1'b0, s_tdata[251:221]};
			im1_s1  <= s_tdata[125:95];
			im2_s1  <= s_tdata[251:221];
		end
	end

	// stage 2: magnitudes and the bounding box test
	logic [POS_W:0] adx_c, ady_c;
	side_t          side_c2, side_s2;
	logic           near_s2;

	assign adx_c = dx_s1[POS_W] ? 33'(-dx_s1) : 33'(dx_s1);
	assign ady_c = dy_s1[POS_W] ? 33'(-dy_s1) : 33'(dy_s1);

	always_comb begin
		side_c2       = '0;
		side_c2.x1    = x1_s1;
		side_c2.y1    = y1_s1;
		side_c2.x2    = x2_s1;
		side_c2.y2    = y2_s1;
		side_c2.neg_x = dx_s1[POS_W];
		side_c2.neg_y = dy_s1[POS_W];
		side_c2.adx   = adx_c[POS_W-1:0];
		side_c2.ady   = ady_c[POS_W-1:0];
		side_c2.m     = m_s1;
		side_c2.im1   = im1_s1;
		side_c2.im2   = im2_s1;
		side_c2.msum  = msum_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_c2;
			near_s2 <= (adx_c < {1'b0, m_s1}) && (ady_c < {1'b0, m_s1});
		end
	end

	// stage 3: squares
	logic [63:0] sx_s3, sy_s3, mm_s3;
	side_t       side_s3;
	logic        near_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s3   <= 64'(side_s2.adx) * 64'(side_s2.adx);
			sy_s3   <= 64'(side_s2.ady) * 64'(side_s2.ady);
			mm_s3   <= 64'(side_s2.m) * 64'(side_s2.m);
			side_s3 <= side_s2;
			near_s3 <= near_s2;
		end
	end

	// stage 4: squared distance, overlap and degenerate decisions
	logic [64:0] d2_c;
	logic        ovl_c, degen_c;
	side_t       side_c4;
	logic [63:0] d2_s4;
	side_t       side_s4;

	assign d2_c    = {1'b0, sx_s3} + {1'b0, sy_s3};
	assign ovl_c   = near_s3 & ~d2_c[64] & (d2_c[63:0] < mm_s3);
	assign degen_c = ovl_c & ((d2_c[63:0] == '0) | (side_s3.msum == '0));

	always_comb begin
		side_c4       = side_s3;
		side_c4.degen = degen_c;
		side_c4.hit   = ovl_c & ~degen_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s4   <= d2_c[63:0];
			side_s4 <= side_c4;
		end
	end

	// square root of the squared distance; carry the sideband alongside
	logic [POS_W-1:0] len_c;
	side_t            side_sq [SQ_STAGES];

	cpor_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (d2_s4),
		.root (len_c)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_sq[0] <= side_s4;
			for (int i = 1; i < SQ_STAGES; i++)
				side_sq[i] <= side_sq[i-1];
		end
	end

	// stage 5: penetration depth
	logic [POS_W-1:0] pen_s5;
	side_t            side_c5;
	side_t            side_s5;

	always_comb begin
		side_c5     = side_sq[SQ_STAGES-1];
		side_c5.len = len_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pen_s5  <= side_sq[SQ_STAGES-1].m - len_c;
			side_s5 <= side_c5;
		end
	end

	// stage 6: depth times each inverse mass
	logic [63:0] p1_s6, p2_s6;
	side_t       side_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s6   <= 64'(pen_s5) * 64'(side_s5.im1);
			p2_s6   <= 64'(pen_s5) * 64'(side_s5.im2);
			side_s6 <= side_s5;
		end
	end

	// share of the depth per circle
	logic [POS_W-1:0] share1_c, share2_c;
	side_t            side_da [DIV_STAGES];

	cpor_div u_div_share1 (
		.clk (clk),
		.en  (en),
		.num (p1_s6),
		.den (side_s6.msum),
		.quo (share1_c)
	);

	cpor_div u_div_share2 (
		.clk (clk),
		.en  (en),
		.num (p2_s6),
		.den (side_s6.msum),
		.quo (share2_c)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_da[0] <= side_s6;
			for (int i = 1; i < DIV_STAGES; i++)
				side_da[i] <= side_da[i-1];
		end
	end

	// stage 7: component magnitude times share
	logic [63:0] prod_s7 [4];
	side_t       side_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s7[0] <= 64'(side_da[DIV_STAGES-1].adx) * 64'(share1_c);
			prod_s7[1] <= 64'(side_da[DIV_STAGES-1].ady) * 64'(share1_c);
			prod_s7[2] <= 64'(side_da[DIV_STAGES-1].adx) * 64'(share2_c);
			prod_s7[3] <= 64'(side_da[DIV_STAGES-1].ady) * 64'(share2_c);
			side_s7    <= side_da[DIV_STAGES-1];
		end
	end

	// displacement magnitudes, divided by the center distance
	logic [POS_W-1:0] disp_c [4];
	side_t            side_db [DIV_STAGES];

	genvar g;
	generate
		for (g = 0; g < 4; g++) begin : g_disp
			cpor_div u_div_disp (
				.clk (clk),
				.en  (en),
				.num (prod_s7[g]),
				.den (side_s7.len),
				.quo (disp_c[g])
			);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			side_db[0] <= side_s7;
			for (int i = 1; i < DIV_STAGES; i++)
				side_db[i] <= side_db[i-1];
		end
	end

	// stage 8: apply signed displacements, saturate, register the result
	side_t                   side_f;
	logic signed [POS_W+1:0] dq_c [4];
	logic signed [POS_W+1:0] ex1, ey1, ex2, ey2;
	logic [POS_W-1:0]        nx1_c, ny1_c, nx2_c, ny2_c;
	logic [POS_W-1:0]        nx1_s8, ny1_s8, nx2_s8, ny2_s8;
	logic                    ovl_s8, degen_s8;

	assign side_f = side_db[DIV_STAGES-1];
	assign ex1    = 34'(side_f.x1);
	assign ey1    = 34'(side_f.y1);
	assign ex2    = 34'(side_f.x2);
	assign ey2    = 34'(side_f.y2);

	always_comb begin
		for (int i = 0; i < 4; i++)
			dq_c[i] = signed'({2'b00, disp_c[i]});
		if (side_f.hit) begin
			nx1_c = sat32(side_f.neg_x ? ex1 - dq_c[0] : ex1 + dq_c[0]);
			ny1_c = sat32(side_f.neg_y ? ey1 - dq_c[1] : ey1 + dq_c[1]);
			nx2_c = sat32(side_f.neg_x ? ex2 + dq_c[2] : ex2 - dq_c[2]);
			ny2_c = sat32(side_f.neg_y ? ey2 + dq_c[3] : ey2 - dq_c[3]);
		end else begin
			nx1_c = side_f.x1;
			ny1_c = side_f.y1;
			nx2_c = side_f.x2;
			ny2_c = side_f.y2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx1_s8   <= nx1_c;
			ny1_s8   <= ny1_c;
			nx2_s8   <= nx2_c;
			ny2_s8   <= ny2_c;
			ovl_s8   <= side_f.hit;
			degen_s8 <= side_f.degen;
		end
	end

	assign m_tvalid                = vld_q[PIPE_LAT-1];
	assign m_tdata                 = {ny2_s8, nx2_s8, ny1_s8, nx1_s8};
	assign m_tuser[TU_OVERLAPPED]  = ovl_s8;
	assign m_tuser[TU_DEGENERATE]  = degen_s8;

endmodule

### rtl/core/cpor_checker.sv
// Port-level checker for the circle pair overlap resolver, bound to the top.
// Depends on circle_pair_overlap_resolver_assert.svh and cpor_pkg.
`include "circle_pair_overlap_resolver_assert.svh"

module cpor_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata,
	input logic [1:0]   m_tuser
);
	import cpor_pkg::*;

	// a stalled result holds its payload
	`CPOR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

	// a pair is never both resolved and degenerate
	`CPOR_ASSERT_SAME(a_flags_excl, m_tvalid, !(m_tuser[TU_OVERLAPPED] && m_tuser[TU_DEGENERATE]), "overlapped and degenerate both set")

	// an output stall freezes the input side
	`CPOR_ASSERT_SAME(a_stall_back, m_tvalid && !m_tready, !s_tready, "input taken during output stall")

	// an empty output stage never blocks input
	`CPOR_ASSERT_SAME(a_ready_free, !m_tvalid, s_tready, "input blocked with empty output")

endmodule

bind circle_pair_overlap_resolver cpor_checker u_cpor_checker (.*);
